// ----- rtl/bmc_pkg.sv -----
// Package for the button debounce and multi-tap classifier.
// Holds the transfer payload types, the configuration types and the codes.
// No dependencies.
`default_nettype none

package bmc_pkg;

  // Number of layers present; a layer select beyond it is ignored.
  localparam int unsigned LAYER_COUNT = 3;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] DEBOUNCE_RST     = 16'd20;
  localparam logic [15:0] TAP_WINDOW_RST   = 16'd300;
  localparam logic [15:0] SINGLE_DELAY_RST = 16'd250;
  localparam logic [7:0]  CONTROL_TAPS_RST = 8'd5;
  localparam logic [7:0]  TOGGLE_TAPS_RST  = 8'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_TAP_WINDOW   = 3'd1,
    CFG_SINGLE_DELAY = 3'd2,
    CFG_CONTROL_EN   = 3'd3,
    CFG_CONTROL_TAPS = 3'd4,
    CFG_TOGGLE_EN    = 3'd5,
    CFG_TOGGLE_TAPS  = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    GEST_NONE    = 3'd0,
    GEST_CONTROL = 3'd1,
    GEST_TOGGLE  = 3'd2,
    GEST_LAYER   = 3'd3,
    GEST_SINGLE  = 3'd4
  } gesture_e;

  typedef struct packed {
    logic [15:0] settle_ticks;
    logic [15:0] tap_gap_ticks;
    logic [15:0] single_delay_ticks;
    logic        control_enable;
    logic [7:0]  control_taps;
    logic        toggle_enable;
    logic [7:0]  toggle_taps;
  } cfg_t;

  typedef struct packed {
    logic              raw_level;
    logic [TICK_W-1:0] now_tick;
  } in_item_t;

  typedef struct packed {
    logic       press_edge;
    gesture_e   gesture;
    logic       layer_changed;
    logic [1:0] active_layer;
    logic       single_fire;
  } out_item_t;

endpackage

`default_nettype wire

// ----- rtl/button_debounce_multitap_classifier_core.sv -----
// Pipeline: an input transfer passes the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; the single pass from the input register to the result
// register updates the debounce, tap and layer state in that same cycle.
// Reset: rst_ni clears all state, empties both registers and loads the register defaults.
// Top level of the button classifier; depends on bmc_pkg and bmc_cfg_regs.
`default_nettype none

module button_debounce_multitap_classifier_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bmc_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire bmc_pkg::in_item_t              in_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output bmc_pkg::out_item_t                  out_item_o
);

  bmc_pkg::cfg_t cfg;

  bmc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Pipeline registers.
  logic               in_valid_q;
  bmc_pkg::in_item_t  in_q;
  logic               out_valid_q;
  bmc_pkg::out_item_t out_q, out_d;
  logic               adv;
  logic               in_ready;

  // Classifier state.
  logic        stable_q, stable_d;
  logic        last_raw_q, last_raw_d;
  logic [31:0] raw_chg_q, raw_chg_d;
  logic [7:0]  taps_q, taps_d;
  logic [31:0] last_tap_q, last_tap_d;
  logic        pend_q, pend_d;
  logic [31:0] due_q, due_d;
  logic [1:0]  layer_q, layer_d;

  // The result stage moves when its register is empty or being drained.
  // The input register takes a transfer when it is empty or its item moves on.
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || adv;
  assign in_stall_o = !in_ready;

  // Wrapping time differences against the old state.
  logic [31:0] raw_age, tap_gap, due_diff;
  logic        raw_chg, stable_upd, press_edge, classify, arm_single, fire;
  logic [1:0]  target;

  assign raw_age  = in_q.now_tick - raw_chg_q;
  assign tap_gap  = in_q.now_tick - last_tap_q;
  assign due_diff = in_q.now_tick - due_q;

  always_comb begin
    raw_chg    = in_q.raw_level != last_raw_q;
    // A fresh raw change has age zero, so it settles at once only with no debounce.
    stable_upd = (raw_chg ? (cfg.settle_ticks == 16'd0)
                          : (raw_age >= {16'd0, cfg.settle_ticks}))
                 && (stable_q != in_q.raw_level);
    press_edge = stable_upd && in_q.raw_level;
    // A press resets the gap to zero, and classification is held off in a step with a press.
    classify   = !press_edge && (taps_q != 8'd0)
                 && (tap_gap > {16'd0, cfg.tap_gap_ticks});

    stable_d   = stable_upd ? in_q.raw_level : stable_q;
    last_raw_d = in_q.raw_level;
    raw_chg_d  = raw_chg ? in_q.now_tick : raw_chg_q;
    taps_d     = taps_q;
    last_tap_d = last_tap_q;
    pend_d     = pend_q;
    due_d      = due_q;
    layer_d    = layer_q;
    arm_single = 1'b0;
    target     = 2'd2;

    out_d               = '0;
    out_d.gesture       = bmc_pkg::GEST_NONE;
    out_d.press_edge    = press_edge;

    // Tap counting; a press cancels a pending single tap.
    if (press_edge) begin
      pend_d     = 1'b0;
      last_tap_d = in_q.now_tick;
      if (taps_q == 8'd0 || tap_gap > {16'd0, cfg.tap_gap_ticks}) begin
        taps_d = 8'd1;
      end else if (taps_q != 8'hFF) begin
        taps_d = taps_q + 8'd1;
      end
    end

    // Classification once the tap window has run out.
    if (classify) begin
      taps_d = 8'd0;
      pend_d = 1'b0;
      if (cfg.control_enable && taps_q == cfg.control_taps) begin
        out_d.gesture = bmc_pkg::GEST_CONTROL;
      end else if (cfg.toggle_enable && taps_q == cfg.toggle_taps) begin
        out_d.gesture = bmc_pkg::GEST_TOGGLE;
      end else if (taps_q == 8'd1) begin
        arm_single    = 1'b1;
        due_d         = in_q.now_tick + {16'd0, cfg.single_delay_ticks};
        out_d.gesture = bmc_pkg::GEST_SINGLE;
      end else begin
        out_d.gesture = bmc_pkg::GEST_LAYER;
        if (taps_q == 8'd2) begin
          target = 2'd0;
        end else if (taps_q == 8'd3) begin
          target = 2'd1;
        end
        if ({30'd0, target} < bmc_pkg::LAYER_COUNT && target != layer_q) begin
          layer_d             = target;
          out_d.layer_changed = 1'b1;
        end
      end
    end

    // Delayed single tap: a freshly armed one is due now only with zero delay.
    fire = arm_single ? (cfg.single_delay_ticks == 16'd0)
                      : (pend_d && !due_diff[31]);
    if (arm_single) begin
      pend_d = !fire;
    end else if (fire) begin
      pend_d = 1'b0;
    end
    out_d.single_fire  = fire;
    out_d.active_layer = layer_d;
  end

  // Control registers and state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      stable_q    <= 1'b0;
      last_raw_q  <= 1'b0;
      raw_chg_q   <= '0;
      taps_q      <= '0;
      last_tap_q  <= '0;
      pend_q      <= 1'b0;
      due_q       <= '0;
      layer_q     <= '0;
    end else begin
      if (in_ready) begin
        in_valid_q  <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (adv && in_valid_q) begin
        stable_q   <= stable_d;
        last_raw_q <= last_raw_d;
        raw_chg_q  <= raw_chg_d;
        taps_q     <= taps_d;
        last_tap_q <= last_tap_d;
        pend_q     <= pend_d;
        due_q      <= due_d;
        layer_q    <= layer_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_ready) begin
      in_q <= in_item_i;
    end
    if (adv && in_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A press cancels any pending single tap, so it never fires with one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.press_edge |-> !out_q.single_fire)
    else $error("single tap fired together with a press edge");

  // Only a layer select may change the layer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.layer_changed |-> out_q.gesture == bmc_pkg::GEST_LAYER)
    else $error("layer changed without a layer select");

  // The layer register never names a layer that is not present.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {30'd0, layer_q} < bmc_pkg::LAYER_COUNT)
    else $error("layer register out of range");

  // The input side stalls only when a full result register is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled while the result stage could move");

  // An item in the input register while the result stage moves yields a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && adv |=> out_valid_q)
    else $error("result lost between the input and result registers");

endmodule

`default_nettype wire

// ----- rtl/bmc_cfg_regs.sv -----
// Configuration register bank of the button classifier.
// Depends on bmc_pkg for the register indexes and the cfg_t type.
`default_nettype none

module bmc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [bmc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [bmc_pkg::CFG_DAT_W-1:0]  cfg_wdata_i,
  output bmc_pkg::cfg_t                       cfg_o
);

  bmc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; an index past the last register is dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bmc_pkg::cfg_idx_e'(cfg_idx_i))
        bmc_pkg::CFG_DEBOUNCE:     cfg_d.settle_ticks       = cfg_wdata_i;
        bmc_pkg::CFG_TAP_WINDOW:   cfg_d.tap_gap_ticks      = cfg_wdata_i;
        bmc_pkg::CFG_SINGLE_DELAY: cfg_d.single_delay_ticks = cfg_wdata_i;
        bmc_pkg::CFG_CONTROL_EN:   cfg_d.control_enable     = cfg_wdata_i[0];
        bmc_pkg::CFG_CONTROL_TAPS: cfg_d.control_taps       = cfg_wdata_i[7:0];
        bmc_pkg::CFG_TOGGLE_EN:    cfg_d.toggle_enable      = cfg_wdata_i[0];
        bmc_pkg::CFG_TOGGLE_TAPS:  cfg_d.toggle_taps        = cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_ticks       <= bmc_pkg::DEBOUNCE_RST;
      cfg_q.tap_gap_ticks      <= bmc_pkg::TAP_WINDOW_RST;
      cfg_q.single_delay_ticks <= bmc_pkg::SINGLE_DELAY_RST;
      cfg_q.control_enable     <= 1'b0;
      cfg_q.control_taps       <= bmc_pkg::CONTROL_TAPS_RST;
      cfg_q.toggle_enable      <= 1'b0;
      cfg_q.toggle_taps        <= bmc_pkg::TOGGLE_TAPS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire
